// ===== hdl/cdq_pkg.sv =====
// Shared constants, command codes and the cell control type of the circular deque.
package cdq_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the streams.
    localparam int OP_W  = 4;
    localparam int POS_W = 4;
    localparam int ST_W  = 2;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_ADD_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 4'd3;
    localparam logic [OP_W-1:0] OP_GET       = 4'd4;
    localparam logic [OP_W-1:0] OP_SET       = 4'd5;
    localparam logic [OP_W-1:0] OP_INSERT    = 4'd6;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

    // Status codes carried in the output tuser.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_INDEX = 2'd3;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // open a gap at the target and load the value there
        logic del;  // close the gap at the target from the right
        logic wr;   // overwrite the target in place
    } t_cell_ctl;

endpackage

// ===== hdl/cdq_cell.sv =====
// One storage cell of the deque chain, holding the element at a fixed logical index.
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = 4,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_value;
            end else if (MY_IDX > i_pos) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end else if (i_ctl.wr) begin
            if (MY_IDX == i_pos) begin
                n_data = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/circular_deque_indexed_unit.sv =====
// Top level of the fixed-capacity deque with indexed access, built as a chain of cells.
//
// Channel   Direction  Handshake                tdata (low bit up)            tuser
// s_*       in         i_s_tvalid / o_s_tready  position, value, zero pad     opcode
// m_*       out        o_m_tvalid / i_m_tready  data_out, count, zero pad     status
//
// The cells sit in logical order, so an insert or a removal at any index is done
// by the cells from that index on loading from a neighbour or the new value at
// the same edge, and reads go through one select across the chain.
// One item is accepted per cycle while the result register is empty or being drained.
// Reset (i_rst_n low at a clock edge) empties the deque and the result register;
// the cell contents are left as they are, since no entry can be read before it is written.
// A stalled output holds its transfer and blocks new input until it is taken.
module circular_deque_indexed_unit
    import cdq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int S_TDATA_W = ((POS_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // position, value, zero pad
    input  logic [OP_W-1:0]      i_s_tuser,   // opcode
    // Output stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // data_out, count, zero pad
    output logic [ST_W-1:0]      o_m_tuser    // status
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Unpacked input fields.
    logic [OP_W-1:0]       w_op;
    logic [POS_W-1:0]      w_pos;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_s_fire;

    // Deque bookkeeping. The cells are kept in logical order, so no
    // front pointer is needed: logical element k always lives in cell k.
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    // Command towards the chain and the read select.
    t_cell_ctl             w_ctl;
    t_cell_ctl             w_ctl_gated;
    logic [IDX_W-1:0]      w_tgt_idx;
    logic [IDX_W-1:0]      w_rd_idx;
    logic                  w_rd_en;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [ST_W-1:0]       w_status;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_idx_ok;

    // Result register.
    logic                  r_m_valid;
    logic [DATA_WIDTH-1:0] r_m_data;
    logic [ST_W-1:0]       r_m_status;
    logic [CNT_W-1:0]      r_m_count;

    logic [DATA_WIDTH-1:0] w_cell_data [CAPACITY];

    assign w_op     = i_s_tuser;
    assign w_pos    = i_s_tdata[POS_W-1:0];
    assign w_value  = i_s_tdata[POS_W +: DATA_WIDTH];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_full   = (r_count == CNT_FULL);
    assign w_empty  = (r_count == '0);
    // The position is compared at full width so that a small capacity never aliases it.
    assign w_idx_ok = (32'(w_pos) < 32'(r_count));

    // Decode of one operation against the current count.
    always_comb begin
        w_ctl     = '0;
        w_tgt_idx = IDX_W'(w_pos);
        w_rd_idx  = IDX_W'(w_pos);
        w_rd_en   = 1'b0;
        w_status  = ST_OK;
        n_count   = r_count;
        case (w_op)
            OP_ADD_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_tgt_idx = '0;
                    n_count   = r_count + CNT_ONE;
                end
            end
            OP_ADD_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.wr  = 1'b1;
                    w_tgt_idx = IDX_W'(r_count);
                    n_count   = r_count + CNT_ONE;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.del = 1'b1;
                    w_tgt_idx = '0;
                    w_rd_idx  = '0;
                    w_rd_en   = 1'b1;
                    n_count   = r_count - CNT_ONE;
                end
            end
            OP_POP_BACK: begin
                // The last cell simply drops out of the counted range.
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rd_idx = IDX_W'(r_count - CNT_ONE);
                    w_rd_en  = 1'b1;
                    n_count  = r_count - CNT_ONE;
                end
            end
            OP_GET: begin
                if (!w_idx_ok) begin
                    w_status = ST_INDEX;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            OP_SET: begin
                if (!w_idx_ok) begin
                    w_status = ST_INDEX;
                end else begin
                    w_ctl.wr = 1'b1;
                end
            end
            OP_INSERT: begin
                // The index check takes precedence over the full check.
                if (!w_idx_ok) begin
                    w_status = ST_INDEX;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + CNT_ONE;
                end
            end
            OP_REMOVE_AT: begin
                if (!w_idx_ok) begin
                    w_status = ST_INDEX;
                end else begin
                    w_ctl.del = 1'b1;
                    w_rd_en   = 1'b1;
                    n_count   = r_count - CNT_ONE;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // Unused codes leave everything unchanged and report success.
            end
        endcase
    end

    // The chain only moves on an accepted transfer.
    assign w_ctl_gated = w_s_fire ? w_ctl : '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell_data[g];
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end

        cdq_cell #(
            .CELL_IDX   (g),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl_gated),
            .i_pos   (w_tgt_idx),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

    // Read select across the chain; it yields zero when nothing is read.
    always_comb begin
        w_rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_rd_en && (w_rd_idx == IDX_W'(i))) begin
                w_rd_data = w_cell_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_s_fire) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_m_data   <= w_rd_data;
            r_m_status <= w_status;
            r_m_count  <= n_count;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_TDATA_W'({r_m_count, r_m_data});
    assign o_m_tuser  = r_m_status;

    // The count never runs past the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("deque count beyond capacity");

    // Without an accepted transfer the count holds.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s_fire |=> $stable(r_count))
        else $error("deque count changed without a transfer");

    // A refused add or insert leaves the count alone.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && w_status == ST_FULL) |=> $stable(r_count))
        else $error("count moved on a full refusal");

    // Every accepted item leaves a result waiting, carrying the new count.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> (r_m_valid && r_m_count == r_count))
        else $error("accepted item produced no matching result");

endmodule
